### src/bnk_pkg.sv
// banked register file package: processor mode codes, request and status codes,
// physical slot map and the decode record passed from the decoder to the top level
// no dependencies
package bnk_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned INDEX_W = 5;
   localparam int unsigned SLOT_W  = 6;
   localparam int unsigned STAT_W  = 2;

   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   localparam logic [DATA_W-1:0] CPSR_RESET = 32'h0000_00D3;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [INDEX_W-1:0] IDX_R7   = 5'd7;
   localparam logic [INDEX_W-1:0] IDX_R12  = 5'd12;
   localparam logic [INDEX_W-1:0] IDX_SP   = 5'd13;
   localparam logic [INDEX_W-1:0] IDX_LR   = 5'd14;
   localparam logic [INDEX_W-1:0] IDX_PC   = 5'd15;
   localparam logic [INDEX_W-1:0] IDX_CPSR = 5'd16;
   localparam logic [INDEX_W-1:0] IDX_SPSR = 5'd17;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BADIDX  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BADMODE = 2'd2;

   localparam int unsigned BANK_DEPTH = 36;

   localparam logic [SLOT_W-1:0] SLOT_NONE     = 6'd0;
   localparam logic [SLOT_W-1:0] SLOT_USR_TRIO = 6'd13;
   localparam logic [SLOT_W-1:0] SLOT_FIQ_LOW  = 6'd16;
   localparam logic [SLOT_W-1:0] SLOT_FIQ_TRIO = 6'd21;
   localparam logic [SLOT_W-1:0] SLOT_IRQ_TRIO = 6'd24;
   localparam logic [SLOT_W-1:0] SLOT_SVC_TRIO = 6'd27;
   localparam logic [SLOT_W-1:0] SLOT_ABT_TRIO = 6'd30;
   localparam logic [SLOT_W-1:0] SLOT_UND_TRIO = 6'd33;

   typedef struct packed {
      logic                mem_en;
      logic                mem_wr;
      logic [SLOT_W-1:0]   slot;
      logic                cpsr_wr;
      logic                from_mem;
      logic [DATA_W-1:0]   data;
      logic [STAT_W-1:0]   status;
      logic                privileged;
      logic                has_spsr;
   } dec_type;

   function automatic logic mode_has_spsr(input logic [4:0] mode);
      return (mode == MODE_FIQ) || (mode == MODE_IRQ) || (mode == MODE_SVC) ||
             (mode == MODE_ABT) || (mode == MODE_UND);
   endfunction

   // base slot of the sp/lr/spsr trio, SLOT_NONE for an unknown mode
   function automatic logic [SLOT_W-1:0] trio_base(input logic [4:0] mode);
      logic [SLOT_W-1:0] base;
      unique case (mode)
         MODE_USR, MODE_SYS: base = SLOT_USR_TRIO;
         MODE_FIQ:           base = SLOT_FIQ_TRIO;
         MODE_IRQ:           base = SLOT_IRQ_TRIO;
         MODE_SVC:           base = SLOT_SVC_TRIO;
         MODE_ABT:           base = SLOT_ABT_TRIO;
         MODE_UND:           base = SLOT_UND_TRIO;
         default:            base = SLOT_NONE;
      endcase
      return base;
   endfunction

endpackage

### src/bnk_if.sv
// request and response channel interfaces of the banked register file
// depends on bnk_pkg
interface bnk_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic [bnk_pkg::INDEX_W-1:0]        reg_index;
   logic                               user_bank;
   logic [bnk_pkg::DATA_W-1:0]         write_value;

   modport source (output valid, output req_type, output reg_index, output user_bank,
                   output write_value, input ready);
   modport sink   (input valid, input req_type, input reg_index, input user_bank,
                   input write_value, output ready);
endinterface

interface bnk_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bnk_pkg::DATA_W-1:0]         read_data;
   logic [bnk_pkg::STAT_W-1:0]         status;
   logic                               privileged;
   logic                               has_spsr;

   modport source (output valid, output read_data, output status, output privileged,
                   output has_spsr, input ready);
   modport sink   (input valid, input read_data, input status, input privileged,
                   input has_spsr, output ready);
endinterface

### src/banked_register_file.sv
// banked register file top level: cpsr register, 36-entry banked register memory
// and response register; depends on bnk_pkg, bnk_if and bnk_decode
//
// usage
// - req_chan carries one request per handshake: read or write of r0..r15, the cpsr
//   or the spsr as seen in the current mode, or in the user bank when user_bank is set
// - rsp_chan returns one response per request, in order: read data, status and
//   the privileged and has_spsr flags of the mode before the access
// - the request is decoded against the cpsr in the accept cycle; the memory and
//   the cpsr are updated at that edge, so a following request sees its effect
// - the response is registered and is valid in the cycle after acceptance
// - throughput is one request per cycle while rsp_chan does not stall, set by the single memory port
// - when rsp_chan stalls, the response holds and req_chan is held off until the
//   response is taken; ready on req_chan follows rsp_chan ready in the same cycle
// - reset sets the cpsr to supervisor mode with irq and fiq masked (0xd3) and
//   empties the response register; the banked registers are not cleared and
//   must be written before they are read
module banked_register_file (
   input  logic          clock,
   input  logic          reset,
   bnk_req_if.sink       req_chan,
   bnk_rsp_if.source     rsp_chan
);

   bnk_pkg::dec_type              dec;
   logic                          accept;

   logic [bnk_pkg::DATA_W-1:0]    cpsr_ff;
   logic [bnk_pkg::DATA_W-1:0]    cpsr_in;
   logic                          valid_ff;
   logic                          valid_in;
   logic [bnk_pkg::DATA_W-1:0]    rdata_ff;
   bnk_pkg::dec_type              resp_ff;

   logic [bnk_pkg::DATA_W-1:0]    bank_mem [bnk_pkg::BANK_DEPTH];

   bnk_decode u_decode (
      .req_type  (req_chan.req_type),
      .reg_index (req_chan.reg_index),
      .user_bank (req_chan.user_bank),
      .cpsr      (cpsr_ff),
      .dec       (dec)
   );

   assign req_chan.ready = !valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      cpsr_in  = cpsr_ff;
      valid_in = valid_ff;
      if (accept && dec.cpsr_wr) begin
         cpsr_in = req_chan.write_value;
      end
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpsr_ff  <= bnk_pkg::CPSR_RESET;
         valid_ff <= 1'b0;
      end else begin
         cpsr_ff  <= cpsr_in;
         valid_ff <= valid_in;
      end
   end

   // single-port banked register memory
   always_ff @(posedge clock) begin
      if (accept && dec.mem_en) begin
         if (dec.mem_wr) begin
            bank_mem[dec.slot] <= req_chan.write_value;
         end else begin
            rdata_ff <= bank_mem[dec.slot];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         resp_ff <= dec;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.read_data  = resp_ff.from_mem ? rdata_ff : resp_ff.data;
   assign rsp_chan.status     = resp_ff.status;
   assign rsp_chan.privileged = resp_ff.privileged;
   assign rsp_chan.has_spsr   = resp_ff.has_spsr;

endmodule

### src/bnk_decode.sv
// request decoder: maps index, user-bank flag and current mode to a physical slot,
// status code and mode flags; depends on bnk_pkg
module bnk_decode (
   input  logic                          req_type,
   input  logic [bnk_pkg::INDEX_W-1:0]   reg_index,
   input  logic                          user_bank,
   input  logic [bnk_pkg::DATA_W-1:0]    cpsr,
   output bnk_pkg::dec_type              dec
);

   logic [4:0]                  mode;
   logic [4:0]                  view;
   logic [bnk_pkg::SLOT_W-1:0]  base;
   logic [1:0]                  offset;

   always_comb begin
      mode   = cpsr[4:0];
      view   = user_bank ? bnk_pkg::MODE_USR : mode;
      base   = bnk_pkg::trio_base(view);
      offset = 2'd2;
      if (reg_index == bnk_pkg::IDX_SP) begin
         offset = 2'd0;
      end else if (reg_index == bnk_pkg::IDX_LR) begin
         offset = 2'd1;
      end

      dec            = '0;
      dec.privileged = bnk_pkg::mode_has_spsr(mode) || (mode == bnk_pkg::MODE_SYS);
      dec.has_spsr   = bnk_pkg::mode_has_spsr(mode);
      dec.status     = bnk_pkg::STATUS_OK;

      priority if (reg_index == bnk_pkg::IDX_CPSR) begin
         dec.cpsr_wr = (req_type == bnk_pkg::REQ_WRITE);
         dec.data    = (req_type == bnk_pkg::REQ_WRITE) ? '0 : cpsr;
      end else if (reg_index > bnk_pkg::IDX_SPSR) begin
         dec.status = bnk_pkg::STATUS_BADIDX;
      end else if ((reg_index <= bnk_pkg::IDX_R7) || (reg_index == bnk_pkg::IDX_PC)) begin
         dec.mem_en = 1'b1;
         dec.slot   = {1'b0, reg_index};
      end else if (reg_index <= bnk_pkg::IDX_R12) begin
         dec.mem_en = 1'b1;
         dec.slot   = (view == bnk_pkg::MODE_FIQ) ?
                      bnk_pkg::SLOT_FIQ_LOW + {3'b000, reg_index[2:0]} : {1'b0, reg_index};
      end else if (base == bnk_pkg::SLOT_NONE) begin
         dec.status = bnk_pkg::STATUS_BADMODE;
         dec.data   = (req_type == bnk_pkg::REQ_WRITE) ? '0 : '1;
      end else if ((base == bnk_pkg::SLOT_USR_TRIO) && (offset == 2'd2)) begin
         dec.status = bnk_pkg::STATUS_BADIDX;
      end else begin
         dec.mem_en = 1'b1;
         dec.slot   = base + {4'b0000, offset};
      end

      dec.mem_wr   = dec.mem_en && (req_type == bnk_pkg::REQ_WRITE);
      dec.from_mem = dec.mem_en && (req_type == bnk_pkg::REQ_READ);
   end

endmodule

### verif/banked_register_file_test.sv
`timescale 1ns / 1ps
// self-checking testbench for banked_register_file: directed and random register requests
// checked against a mode-aware register file predictor in a small scoreboard class
// depends on bnk_pkg, bnk_if and the banked_register_file rtl
module banked_register_file_test;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 160;
   localparam int N_RANDOM    = 800;
   localparam int MAX_REPORTS = 10;

   localparam logic [bnk_pkg::INDEX_W-1:0] IDX_R0     = 5'd0;
   localparam logic [bnk_pkg::INDEX_W-1:0] IDX_R8     = 5'd8;
   localparam logic [bnk_pkg::INDEX_W-1:0] IDX_BEYOND = 5'd18;
   localparam logic [bnk_pkg::INDEX_W-1:0] IDX_TOP    = 5'd31;

   typedef struct packed {
      logic                        req_type;
      logic [bnk_pkg::INDEX_W-1:0] reg_index;
      logic                        user_bank;
      logic [bnk_pkg::DATA_W-1:0]  write_value;
   } access_type;

   typedef struct packed {
      logic [bnk_pkg::DATA_W-1:0] read_data;
      logic [bnk_pkg::STAT_W-1:0] status;
      logic                       privileged;
      logic                       has_spsr;
   } reply_type;

   typedef struct {
      bit                         have_slot;
      int                         slot;
      logic [bnk_pkg::STAT_W-1:0] status;
      logic [bnk_pkg::DATA_W-1:0] data;
   } slot_pick_type;

   class regfile_scoreboard;
      logic [bnk_pkg::DATA_W-1:0] bank [bnk_pkg::BANK_DEPTH];
      bit                         written [bnk_pkg::BANK_DEPTH];
      logic [bnk_pkg::DATA_W-1:0] cpsr;
      reply_type                  pending_replies [$];
      int                         mismatches;

      function new();
         cpsr = bnk_pkg::CPSR_RESET;
         foreach (written[i]) written[i] = 1'b0;
         mismatches = 0;
      endfunction

      // physical slot of a request in the current mode
      function slot_pick_type lookup(access_type a);
         slot_pick_type p;
         logic [4:0]    view;
         int            base;
         p.have_slot = 1'b0;
         p.slot      = 0;
         p.status    = bnk_pkg::STATUS_OK;
         p.data      = '0;
         view = a.user_bank ? bnk_pkg::MODE_USR : cpsr[4:0];
         if (a.reg_index == bnk_pkg::IDX_CPSR) begin
         end else if (a.reg_index > bnk_pkg::IDX_SPSR) begin
            p.status = bnk_pkg::STATUS_BADIDX;
         end else if (a.reg_index <= bnk_pkg::IDX_R7 || a.reg_index == bnk_pkg::IDX_PC) begin
            p.have_slot = 1'b1;
            p.slot      = int'(a.reg_index);
         end else if (a.reg_index <= bnk_pkg::IDX_R12) begin
            p.have_slot = 1'b1;
            if (view == bnk_pkg::MODE_FIQ)
               p.slot = int'(bnk_pkg::SLOT_FIQ_LOW) + int'(a.reg_index) - int'(IDX_R8);
            else
               p.slot = int'(a.reg_index);
         end else begin
            case (view)
               bnk_pkg::MODE_USR, bnk_pkg::MODE_SYS: base = int'(bnk_pkg::SLOT_USR_TRIO);
               bnk_pkg::MODE_FIQ: base = int'(bnk_pkg::SLOT_FIQ_TRIO);
               bnk_pkg::MODE_IRQ: base = int'(bnk_pkg::SLOT_IRQ_TRIO);
               bnk_pkg::MODE_SVC: base = int'(bnk_pkg::SLOT_SVC_TRIO);
               bnk_pkg::MODE_ABT: base = int'(bnk_pkg::SLOT_ABT_TRIO);
               bnk_pkg::MODE_UND: base = int'(bnk_pkg::SLOT_UND_TRIO);
               default:           base = int'(bnk_pkg::SLOT_NONE);
            endcase
            if (base == int'(bnk_pkg::SLOT_NONE)) begin
               p.status = bnk_pkg::STATUS_BADMODE;
               if (a.req_type == bnk_pkg::REQ_READ) p.data = '1;
            end else if (base == int'(bnk_pkg::SLOT_USR_TRIO) &&
                         a.reg_index == bnk_pkg::IDX_SPSR) begin
               p.status = bnk_pkg::STATUS_BADIDX;
            end else begin
               p.have_slot = 1'b1;
               // sp, lr, then spsr in each trio
               if (a.reg_index == bnk_pkg::IDX_SPSR)
                  p.slot = base + 2;
               else
                  p.slot = base + int'(a.reg_index) - int'(bnk_pkg::IDX_SP);
            end
         end
         return p;
      endfunction

      function bit reads_unwritten(access_type a);
         slot_pick_type p;
         p = lookup(a);
         return a.req_type == bnk_pkg::REQ_READ && p.have_slot && !written[p.slot];
      endfunction

      function void note_request(access_type a);
         reply_type     r;
         slot_pick_type p;
         logic [4:0]    mode;
         mode = cpsr[4:0];
         p = lookup(a);
         r.has_spsr   = (mode == bnk_pkg::MODE_FIQ) || (mode == bnk_pkg::MODE_IRQ) ||
                        (mode == bnk_pkg::MODE_SVC) || (mode == bnk_pkg::MODE_ABT) ||
                        (mode == bnk_pkg::MODE_UND);
         r.privileged = r.has_spsr || (mode == bnk_pkg::MODE_SYS);
         r.read_data  = p.data;
         r.status     = p.status;
         if (a.reg_index == bnk_pkg::IDX_CPSR) begin
            if (a.req_type == bnk_pkg::REQ_WRITE) cpsr = a.write_value;
            else r.read_data = cpsr;
         end else if (p.have_slot) begin
            if (a.req_type == bnk_pkg::REQ_WRITE) begin
               bank[p.slot]    = a.write_value;
               written[p.slot] = 1'b1;
            end else begin
               r.read_data = bank[p.slot];
            end
         end
         pending_replies.push_back(r);
      endfunction

      function void check_response(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected response data=%h status=%0d", got.read_data, got.status);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.read_data !== want.read_data || got.status !== want.status ||
             got.privileged !== want.privileged || got.has_spsr !== want.has_spsr) begin
            if (mismatches < MAX_REPORTS)
               $display({"mismatch: expected data=%h status=%0d priv=%b spsr=%b, ",
                         "got data=%h status=%0d priv=%b spsr=%b"},
                        want.read_data, want.status, want.privileged, want.has_spsr,
                        got.read_data, got.status, got.privileged, got.has_spsr);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   requests_sent = 0;
   int   stall_cycles  = 0;
   logic [4:0] mode_table [0:6] = '{bnk_pkg::MODE_USR, bnk_pkg::MODE_FIQ, bnk_pkg::MODE_IRQ,
                                    bnk_pkg::MODE_SVC, bnk_pkg::MODE_ABT, bnk_pkg::MODE_UND,
                                    bnk_pkg::MODE_SYS};
   regfile_scoreboard sb = new();

   bnk_req_if req_chan ();
   bnk_rsp_if rsp_chan ();

   banked_register_file u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   function automatic bit calm_phase();
      return requests_sent >= 450 && requests_sent < 600;
   endfunction

   function automatic access_type make_access(logic t, logic [bnk_pkg::INDEX_W-1:0] idx,
                                              logic ub, logic [bnk_pkg::DATA_W-1:0] wv);
      access_type a;
      a.req_type    = t;
      a.reg_index   = idx;
      a.user_bank   = ub;
      a.write_value = wv;
      return a;
   endfunction

   function automatic access_type random_access();
      access_type a;
      int         pick;
      pick          = $urandom_range(99);
      a.req_type    = 1'($urandom_range(1));
      a.user_bank   = ($urandom_range(99) < 20);
      a.write_value = $urandom;
      if (pick < 10) begin
         a.req_type  = bnk_pkg::REQ_WRITE;
         a.reg_index = bnk_pkg::IDX_CPSR;
         if ($urandom_range(99) < 85) a.write_value[4:0] = mode_table[$urandom_range(6)];
      end else if (pick < 15) begin
         a.reg_index = bnk_pkg::IDX_CPSR;
      end else if (pick < 25) begin
         a.reg_index = bnk_pkg::IDX_SPSR;
      end else if (pick < 30) begin
         a.reg_index = bnk_pkg::INDEX_W'($urandom_range(int'(IDX_BEYOND), int'(IDX_TOP)));
      end else begin
         a.reg_index = bnk_pkg::INDEX_W'($urandom_range(int'(bnk_pkg::IDX_PC)));
      end
      return a;
   endfunction

   task automatic send(input access_type a);
      // a read of a never-written register becomes a write
      if (sb.reads_unwritten(a)) a.req_type = bnk_pkg::REQ_WRITE;
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= a.req_type;
      req_chan.reg_index   <= a.reg_index;
      req_chan.user_bank   <= a.user_bank;
      req_chan.write_value <= a.write_value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(a);
      requests_sent++;
      while (!calm_phase() && $urandom_range(99) < 28) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   initial begin
      reply_type got;
      int        hold_left;
      bit        held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.read_data  = rsp_chan.read_data;
            got.status     = rsp_chan.status;
            got.privileged = rsp_chan.privileged;
            got.has_spsr   = rsp_chan.has_spsr;
            sb.check_response(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!held && requests_sent >= 250) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= calm_phase() || ($urandom_range(99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("banked_register_file_test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= bnk_pkg::REQ_READ;
      req_chan.reg_index   <= '0;
      req_chan.user_bank   <= 1'b0;
      req_chan.write_value <= '0;
      rsp_chan.ready       <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // supervisor mode after reset
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_CPSR, 1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, IDX_R0,            1'b0, 32'h0000_0000));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_R7,   1'b0, 32'hFFFF_FFFF));
      send(make_access(bnk_pkg::REQ_READ,  IDX_R0,            1'b0, '0));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_R7,   1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_PC,   1'b0, 32'hA5A5_A5A5));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_PC,   1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_SP,   1'b0, 32'h1234_5678));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_LR,   1'b0, 32'h8765_4321));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_SPSR, 1'b0, 32'hDEAD_BEEF));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SPSR, 1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_SP,   1'b1, 32'hCAFE_F00D));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SPSR, 1'b1, '0));
      send(make_access(bnk_pkg::REQ_WRITE, IDX_BEYOND,        1'b0, 32'h5555_AAAA));
      send(make_access(bnk_pkg::REQ_READ,  IDX_TOP,           1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, IDX_R8,            1'b1, 32'h1111_1111));
      // fiq bank
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_CPSR, 1'b0,
                       {24'h00, 3'b110, bnk_pkg::MODE_FIQ}));
      send(make_access(bnk_pkg::REQ_WRITE, IDX_R8,            1'b0, 32'h2222_2222));
      send(make_access(bnk_pkg::REQ_READ,  IDX_R8,            1'b0, '0));
      send(make_access(bnk_pkg::REQ_READ,  IDX_R8,            1'b1, '0));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_SPSR, 1'b0, 32'h0BAD_F1F0));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SPSR, 1'b0, '0));
      // user mode, no spsr
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_CPSR, 1'b0,
                       {27'h7FF_FFFF, bnk_pkg::MODE_USR}));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SPSR, 1'b0, '0));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SP,   1'b0, '0));
      // unknown mode
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_CPSR, 1'b0, 32'h0000_0000));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SP,   1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_LR,   1'b0, 32'h0F0F_0F0F));
      send(make_access(bnk_pkg::REQ_READ,  IDX_R0,            1'b0, '0));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SP,   1'b1, '0));
      // system mode, then cpsr write through the user view
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_CPSR, 1'b0,
                       {27'h000_0000, bnk_pkg::MODE_SYS}));
      send(make_access(bnk_pkg::REQ_READ,  bnk_pkg::IDX_SPSR, 1'b0, '0));
      send(make_access(bnk_pkg::REQ_WRITE, bnk_pkg::IDX_CPSR, 1'b1, bnk_pkg::CPSR_RESET));

      repeat (N_RANDOM) send(random_access());
      req_chan.valid <= 1'b0;

      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
         $display("banked_register_file_test passed");
      else
         $display("banked_register_file_test failed");
      $finish;
   end
endmodule

### filelist.f
src/bnk_pkg.sv
src/bnk_if.sv
src/bnk_decode.sv
src/banked_register_file.sv
verif/banked_register_file_test.sv
